// File: hdl/cra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg: shared types for the cell to packet reassembler
// Cell and packet descriptor layouts, the classified command held in the
// cell queue, and the queue head handed to the reassembly engine.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int SEQ_W  = 32;
    localparam int IDX_W  = 16;
    localparam int PAY_W  = 11;
    localparam int STN_W  = 16;
    localparam int TIME_W = 32;
    localparam int LEN_W  = 20;

    typedef struct packed {
        logic              is_start;
        logic              is_end;
        logic [SEQ_W-1:0]  msg_seq;
        logic [IDX_W-1:0]  cell_index;
        logic [PAY_W-1:0]  cell_payload_bits;
        logic [STN_W-1:0]  source_id;
        logic [STN_W-1:0]  dest_id;
        logic [TIME_W-1:0] send_time;
    } t_cell_in;

    typedef struct packed {
        logic [STN_W-1:0]  pkt_source;
        logic [STN_W-1:0]  pkt_dest;
        logic [SEQ_W-1:0]  pkt_msg_seq;
        logic [TIME_W-1:0] pkt_send_time;
        logic [LEN_W-1:0]  pkt_length_bits;
    } t_pkt_out;

    typedef enum logic {
        CELL_OPEN = 1'b0,
        CELL_CONT = 1'b1
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic              last;
        logic [SEQ_W-1:0]  seq;
        logic [IDX_W-1:0]  idx;
        logic [PAY_W-1:0]  pay;
        logic [STN_W-1:0]  src;
        logic [STN_W-1:0]  dst;
        logic [TIME_W-1:0] tim;
    } t_cell_cmd;

    typedef struct packed {
        logic      valid;
        t_cell_cmd cmd;
    } t_q_head;

endpackage

// File: hdl/cra_cell_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_cell_queue: cell intake and command queue
// Accepts cell descriptors, classifies each as an opening or a continuation
// cell and holds the commands until the reassembly engine takes them.
// ----------------------------------------------------------------------------
module cra_cell_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cra_pkg::t_cell_in i_cell,
    output logic              o_full,
    input  logic              i_pop,
    output cra_pkg::t_q_head  o_head
);
    import cra_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell_cmd        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_cell_cmd        w_cmd;
    logic             w_wr;
    logic             w_rd;

    // classification of the incoming cell
    always_comb begin
        w_cmd.op   = i_cell.is_start ? CELL_OPEN : CELL_CONT;
        w_cmd.last = i_cell.is_end;
        w_cmd.seq  = i_cell.msg_seq;
        w_cmd.idx  = i_cell.cell_index;
        w_cmd.pay  = i_cell.cell_payload_bits;
        w_cmd.src  = i_cell.source_id;
        w_cmd.dst  = i_cell.dest_id;
        w_cmd.tim  = i_cell.send_time;
    end

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

// File: hdl/cra_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_engine: reassembly state and packet output
// Checks each queued cell against the open reassembly, updates the message,
// index and saturating length registers and emits a packet on an end cell it takes.
// ----------------------------------------------------------------------------
module cra_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cra_pkg::t_q_head  i_head,
    output logic              o_head_pop,
    output cra_pkg::t_pkt_out o_pkt,
    output logic              o_empty,
    input  logic              i_pop
);
    import cra_pkg::*;

    logic             r_in_progress, n_in_progress;
    logic [SEQ_W-1:0] r_exp_seq, n_exp_seq;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic             r_out_valid, n_out_valid;
    t_pkt_out         r_pkt, n_pkt;

    t_cell_cmd        w_cmd;
    logic             w_match;
    logic [LEN_W:0]   w_sum;
    logic [LEN_W-1:0] w_new_len;
    logic             w_take;
    logic             w_emit;

    assign w_cmd = i_head.cmd;

    // output slot frees in the same cycle it is popped
    assign o_head_pop = i_head.valid && (!r_out_valid || i_pop);

    assign w_match = r_in_progress && (w_cmd.seq == r_exp_seq)
                     && (w_cmd.idx == r_last_idx + 1'b1);
    assign w_sum   = {1'b0, r_accum} + (LEN_W + 1)'(w_cmd.pay);

    always_comb begin
        if (w_cmd.op == CELL_OPEN) begin
            w_new_len = LEN_W'(w_cmd.pay);
        end else if (w_sum[LEN_W]) begin
            w_new_len = '1;
        end else begin
            w_new_len = w_sum[LEN_W-1:0];
        end
    end

    assign w_take = o_head_pop && ((w_cmd.op == CELL_OPEN) || w_match);
    assign w_emit = w_take && w_cmd.last;

    always_comb begin
        n_in_progress = r_in_progress;
        n_exp_seq     = r_exp_seq;
        n_last_idx    = r_last_idx;
        n_accum       = r_accum;
        n_out_valid   = r_out_valid && !i_pop;
        n_pkt         = r_pkt;
        if (w_take) begin
            n_in_progress = 1'b1;
            n_last_idx    = w_cmd.idx;
            n_accum       = w_new_len;
            if (w_cmd.op == CELL_OPEN) begin
                n_exp_seq = w_cmd.seq;
            end
        end
        if (w_emit) begin
            n_out_valid           = 1'b1;
            n_pkt.pkt_source      = w_cmd.src;
            n_pkt.pkt_dest        = w_cmd.dst;
            n_pkt.pkt_msg_seq     = w_cmd.seq;
            n_pkt.pkt_send_time   = w_cmd.tim;
            n_pkt.pkt_length_bits = w_new_len;
            n_in_progress         = 1'b0;
            n_exp_seq             = '1;
            n_last_idx            = '1;
            n_accum               = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_progress <= 1'b0;
            r_exp_seq     <= '1;
            r_last_idx    <= '1;
            r_accum       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_in_progress <= n_in_progress;
            r_exp_seq     <= n_exp_seq;
            r_last_idx    <= n_last_idx;
            r_accum       <= n_accum;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
    end

    assign o_pkt   = r_pkt;
    assign o_empty = !r_out_valid;

endmodule

// File: hdl/cell_to_packet_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_to_packet_reassembler: cell reassembly, receive side
// Rebuilds packet descriptors from a stream of cell descriptors.
//
// Cells enter through a queue-style port: a transaction happens on a clock
// edge with push high and full low. Packets leave the same way: while empty
// is low the oldest packet is on o_pkt, and pop with empty low takes it.
// One cell is taken per cycle when the receiver keeps up; the engine checks
// a cell at the queue head and updates its registers as it takes it. A
// packet is registered onto o_pkt when the engine takes its end cell.
// Cells that open no reassembly, carry the wrong message number or skip an
// index are dropped without a packet.
// When the receiver stalls, the single output register holds its packet,
// the engine stops and the cell queue (QUEUE_DEPTH entries) fills; full
// rises once it is full.
// Synchronous reset closes any open reassembly and empties queue and output.
// ----------------------------------------------------------------------------
module cell_to_packet_reassembler #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  cra_pkg::t_cell_in i_cell,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output cra_pkg::t_pkt_out o_pkt
);
    import cra_pkg::*;

    t_q_head w_head;
    logic    w_head_pop;

    cra_cell_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (i_cell),
        .o_full  (full),
        .i_pop   (w_head_pop),
        .o_head  (w_head)
    );

    cra_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .o_pkt      (o_pkt),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    // engine only takes a command that is there
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head_pop |-> w_head.valid)
        else $error("engine popped an empty cell queue");

    // a full queue always offers a head command
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_head.valid)
        else $error("cell queue full without a head entry");

    // no packet appears without a queued cell behind it
    a_no_phantom_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_head.valid && (empty || pop)) |=> empty)
        else $error("packet appeared with no cell processed");

    // engine keeps draining the queue whenever the output slot is free
    a_drain_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_head.valid && empty) |-> w_head_pop)
        else $error("engine stalled with a free output slot");

endmodule
